FILE: hw/rtl/rhe_pkg.sv
// Shared types, widths and codes of the range histogram engine.
`default_nettype none
package rhe_pkg;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 2;
	localparam int BIN_COUNT_W  = 9;
	localparam int CFG_IDX_W    = 2;
	localparam int DIV_CNT_W    = $clog2(DATA_W + 1);
	localparam int DEF_MAX_BINS = 256;

	// commands
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

	// register reset values
	localparam logic [BIN_COUNT_W-1:0] RST_BIN_COUNT  = 9'd16;
	localparam logic [DATA_W-1:0]      RST_RANGE_LOW  = 32'd0;
	localparam logic [DATA_W-1:0]      RST_RANGE_HIGH = 32'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WIDTH,
		ST_WIDTH_WAIT,
		ST_LOC,
		ST_LOC_WAIT,
		ST_READ,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rhe_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module rhe_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rhe_pkg::div_req_t req,
	output rhe_pkg::div_rsp_t      rsp
);
	logic [rhe_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [rhe_pkg::DATA_W-1:0]    quo_q;
	logic [rhe_pkg::DATA_W-1:0]    rem_q;
	logic [rhe_pkg::DATA_W-1:0]    dvs_q;
	logic [rhe_pkg::DATA_W:0]      trial;
	logic [rhe_pkg::DATA_W:0]      diff;
	logic                          ge;

	assign trial = {rem_q, quo_q[rhe_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= rhe_pkg::DIV_CNT_W'(rhe_pkg::DATA_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rhe_pkg::DIV_CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so 32 bits hold it
			rem_q <= ge ? diff[rhe_pkg::DATA_W-1:0] : trial[rhe_pkg::DATA_W-1:0];
			quo_q <= {quo_q[rhe_pkg::DATA_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
endmodule
`default_nettype wire

FILE: hw/rtl/range_histogram_engine.sv
// Range histogram engine: bin counters over a signed range, updated and read by command.
// Commands are taken when start is high and busy is low. Add and query first run
// (value - range_low) / bin_width through one shared bit-serial divider; then an add
// read-modify-writes its bin and a query reads it. An out-of-range item skips the
// divider and an unused command is dropped. A query answers with a one-cycle
// result_valid strobe and frequency in the cycle after its work ends; the receiver must
// take it then. A clear sweeps all MAX_BINS bins of the memory one bin a cycle and then
// re-derives the bin width. After reset the same clear and width pass run before busy
// first drops. Each register write re-derives the width, on the same divider unless
// the range is empty, with cfg_ready low until that is done.
`default_nettype none
module range_histogram_engine #(
	parameter int MAX_BINS = rhe_pkg::DEF_MAX_BINS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic [rhe_pkg::CMD_W-1:0]          cmd,
	input  wire logic signed [rhe_pkg::DATA_W-1:0]  value,
	output      logic                               result_valid,
	output      logic [rhe_pkg::DATA_W-1:0]         frequency,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [rhe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rhe_pkg::DATA_W-1:0]         cfg_data
);
	localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	rhe_pkg::state_t state_q, state_d;

	logic [rhe_pkg::BIN_COUNT_W-1:0]   bin_count_q;
	logic signed [rhe_pkg::DATA_W-1:0] range_low_q;
	logic signed [rhe_pkg::DATA_W-1:0] range_high_q;
	logic [rhe_pkg::DATA_W-1:0]        width_q;
	logic [rhe_pkg::CMD_W-1:0]         cmd_q;
	logic signed [rhe_pkg::DATA_W-1:0] value_q;
	logic                              in_rng_q;
	logic [ADDR_W-1:0]                 idx_q;
	logic [ADDR_W-1:0]                 clr_idx_q;
	logic [rhe_pkg::DATA_W-1:0]        rd_data_q;
	logic                              result_valid_q;
	logic [rhe_pkg::DATA_W-1:0]        frequency_q;

	logic [rhe_pkg::DATA_W-1:0] mem [MAX_BINS];

	logic [rhe_pkg::BIN_COUNT_W-1:0] eff_n;
	logic                            range_empty;
	logic [rhe_pkg::DATA_W-1:0]      span;
	logic                            clr_last;
	logic                            idx_ok;
	logic                            is_query;
	logic                            in_accept;
	logic                            cfg_accept;
	logic                            rsp_miss;
	logic                            rsp_hit;
	logic                            mem_we;
	logic [ADDR_W-1:0]               mem_wa;
	logic [rhe_pkg::DATA_W-1:0]      mem_wd;
	rhe_pkg::div_req_t               div_req;
	rhe_pkg::div_rsp_t               div_rsp;

	rhe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// zero bins act as one, more than the built capacity saturates
	always_comb begin
		if (bin_count_q == '0)
			eff_n = rhe_pkg::BIN_COUNT_W'(1);
		else if ({23'd0, bin_count_q} > 32'(MAX_BINS))
			eff_n = rhe_pkg::BIN_COUNT_W'(MAX_BINS);
		else
			eff_n = bin_count_q;
	end

	assign range_empty = range_high_q <= range_low_q;
	assign span        = range_high_q - range_low_q;
	assign clr_last    = clr_idx_q == ADDR_W'(MAX_BINS - 1);
	assign idx_ok      = div_rsp.quotient < {23'd0, eff_n};
	assign is_query    = cmd_q == rhe_pkg::CMD_QUERY;
	assign in_accept   = start && !busy;
	assign cfg_accept  = cfg_valid && cfg_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rhe_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd) inside
						rhe_pkg::CMD_ADD, rhe_pkg::CMD_QUERY: state_d = rhe_pkg::ST_LOC;
						rhe_pkg::CMD_CLEAR:                   state_d = rhe_pkg::ST_CLEAR;
						default:                              state_d = rhe_pkg::ST_IDLE;
					endcase
				end else if (cfg_valid) begin
					state_d = rhe_pkg::ST_WIDTH;
				end
			end
			rhe_pkg::ST_CLEAR: begin
				if (clr_last)
					state_d = rhe_pkg::ST_WIDTH;
			end
			rhe_pkg::ST_WIDTH: begin
				state_d = range_empty ? rhe_pkg::ST_IDLE : rhe_pkg::ST_WIDTH_WAIT;
			end
			rhe_pkg::ST_WIDTH_WAIT: begin
				if (div_rsp.done)
					state_d = rhe_pkg::ST_IDLE;
			end
			rhe_pkg::ST_LOC: begin
				state_d = in_rng_q ? rhe_pkg::ST_LOC_WAIT : rhe_pkg::ST_IDLE;
			end
			rhe_pkg::ST_LOC_WAIT: begin
				if (div_rsp.done)
					state_d = idx_ok ? rhe_pkg::ST_READ : rhe_pkg::ST_IDLE;
			end
			rhe_pkg::ST_READ: state_d = rhe_pkg::ST_UPD;
			rhe_pkg::ST_UPD:  state_d = rhe_pkg::ST_IDLE;
			default:          state_d = rhe_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy             = state_q != rhe_pkg::ST_IDLE;
		cfg_ready        = (state_q == rhe_pkg::ST_IDLE) && !start;
		div_req.start    = ((state_q == rhe_pkg::ST_WIDTH) && !range_empty)
			|| ((state_q == rhe_pkg::ST_LOC) && in_rng_q);
		if (state_q == rhe_pkg::ST_WIDTH) begin
			div_req.dividend = span;
			div_req.divisor  = {23'd0, eff_n};
		end else begin
			// value is in range here, so the wrapped difference is exact
			div_req.dividend = value_q - range_low_q;
			div_req.divisor  = width_q;
		end
		rsp_miss = is_query && (((state_q == rhe_pkg::ST_LOC) && !in_rng_q)
			|| ((state_q == rhe_pkg::ST_LOC_WAIT) && div_rsp.done && !idx_ok));
		rsp_hit  = is_query && (state_q == rhe_pkg::ST_UPD);
		mem_we   = (state_q == rhe_pkg::ST_CLEAR)
			|| ((state_q == rhe_pkg::ST_UPD) && (cmd_q == rhe_pkg::CMD_ADD));
		mem_wa   = (state_q == rhe_pkg::ST_CLEAR) ? clr_idx_q : idx_q;
		mem_wd   = (state_q == rhe_pkg::ST_CLEAR) ? '0 : rd_data_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rhe_pkg::ST_CLEAR;
			clr_idx_q      <= '0;
			result_valid_q <= 1'b0;
			width_q        <= rhe_pkg::DATA_W'(1);
			bin_count_q    <= rhe_pkg::RST_BIN_COUNT;
			range_low_q    <= rhe_pkg::RST_RANGE_LOW;
			range_high_q   <= rhe_pkg::RST_RANGE_HIGH;
		end else begin
			state_q        <= state_d;
			result_valid_q <= rsp_miss || rsp_hit;
			if (state_q == rhe_pkg::ST_CLEAR)
				clr_idx_q <= clr_last ? '0 : clr_idx_q + 1'b1;
			if ((state_q == rhe_pkg::ST_WIDTH) && range_empty)
				width_q <= rhe_pkg::DATA_W'(1);
			else if ((state_q == rhe_pkg::ST_WIDTH_WAIT) && div_rsp.done)
				width_q <= div_rsp.quotient
					+ {31'd0, div_rsp.remainder != '0};
			if (cfg_accept) begin
				unique case (cfg_index)
					rhe_pkg::REG_BIN_COUNT:  bin_count_q  <= cfg_data[rhe_pkg::BIN_COUNT_W-1:0];
					rhe_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
					rhe_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q    <= cmd;
			value_q  <= value;
			in_rng_q <= (value >= range_low_q) && (value < range_high_q);
		end
		if ((state_q == rhe_pkg::ST_LOC_WAIT) && div_rsp.done)
			idx_q <= div_rsp.quotient[ADDR_W-1:0];
		frequency_q <= rsp_hit ? rd_data_q : '0;
	end

	// bin memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (state_q == rhe_pkg::ST_READ)
			rd_data_q <= mem[idx_q];
	end

	assign result_valid = result_valid_q;
	assign frequency    = frequency_q;

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a command in flight");

	a_cfg_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_accept |-> !busy && !in_accept)
		else $error("register write taken while a command runs");

	a_width_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> width_q != '0)
		else $error("bin width is zero while idle");

	a_idx_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rhe_pkg::ST_UPD |-> 32'(idx_q) < {23'd0, eff_n})
		else $error("bin index beyond bins in use");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !$past(busy) || $past(state_q) == rhe_pkg::ST_WIDTH
			|| $past(state_q) == rhe_pkg::ST_LOC)
		else $error("divider started outside an issue step");
endmodule
`default_nettype wire
